FILE: rtl/smeu_pkg.sv
// Package for the stack machine execute unit: sizes, opcodes, error codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package smeu_pkg;

  localparam int STACK_DEPTH  = 256;
  localparam int GLOBAL_WORDS = 256;
  localparam int ADDRESS_BITS = 16;

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int SA_W   = $clog2(STACK_DEPTH);
  localparam int GA_W   = $clog2(GLOBAL_WORDS);
  localparam int WORD_W = 32;
  localparam int CMD_W  = 4;
  localparam int ERR_W  = 3;
  localparam int DIV_CNT_W = $clog2(WORD_W + 1);

  typedef enum logic [CMD_W-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_HALT = 4'd4,
    OP_JMP  = 4'd5,
    OP_JZ   = 4'd6,
    OP_JNZ  = 4'd7,
    OP_IN   = 4'd8,
    OP_OUT  = 4'd9,
    OP_LDC  = 4'd10,
    OP_LDV  = 4'd11,
    OP_ST   = 4'd12
  } opcode_t;

  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_ADDR  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_BAD_CMD   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_DIVS,
    ST_DIVW,
    ST_EXEC,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture the input transaction
    logic rd_top;     // read stack at sp-1 and the global word
    logic rd_next;    // capture top, read stack at sp-2
    logic cap_next;   // capture second item
    logic div_start;  // load the divider
    logic exec;       // commit the instruction
    logic load_out;   // move result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/smeu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/smeu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on smeu_pkg.
`default_nettype none
module smeu_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [smeu_pkg::WORD_W-1:0] dividend,
  input  wire logic [smeu_pkg::WORD_W-1:0] divisor,
  output logic                             done,
  output logic      [smeu_pkg::WORD_W-1:0] quotient
);

  localparam int W = smeu_pkg::WORD_W;

  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] dvs_r, dvs_nxt;
  logic         neg_r, neg_nxt;
  logic [smeu_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W:0]   rem_sh;
  logic [W+1:0] diff;

  // magnitudes on start, then restoring steps
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    rem_sh  = {rem_r, quo_r[W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend[W-1] ? (W'(0) - dividend) : dividend;
      dvs_nxt = divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg_nxt = dividend[W-1] ^ divisor[W-1];
      cnt_nxt = smeu_pkg::DIV_CNT_W'(W);
    end else if (cnt_r != '0) begin
      if (!diff[W+1]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = (cnt_r == '0) && !start;
  assign quotient = neg_r ? (W'(0) - quo_r) : quo_r;

endmodule
`default_nettype wire

FILE: rtl/smeu_dp.sv
// Datapath: input capture, stack and global stores, divider, architectural
// registers and the output register. Depends on smeu_pkg, smeu_ram, smeu_div.
`default_nettype none
module smeu_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire smeu_pkg::dp_cmd_t                cmd,
  output smeu_pkg::dp_stat_t                    stat,
  input  wire logic [smeu_pkg::CMD_W-1:0]       in_command,
  input  wire logic signed [31:0]               in_operand,
  input  wire logic signed [31:0]               in_in_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [smeu_pkg::ADDRESS_BITS-1:0]     out_next_address,
  output logic                                  out_out_valid,
  output logic signed [31:0]                    out_out_value,
  output logic                                  out_halted,
  output logic [smeu_pkg::ERR_W-1:0]            out_error_code
);

  localparam int W    = smeu_pkg::WORD_W;
  localparam int SP_W = smeu_pkg::SP_W;
  localparam int SA_W = smeu_pkg::SA_W;
  localparam int GA_W = smeu_pkg::GA_W;
  localparam int AW   = smeu_pkg::ADDRESS_BITS;
  localparam int GLOBAL_N = smeu_pkg::GLOBAL_WORDS;
  localparam int ERR_W_L = smeu_pkg::ERR_W;

  // captured transaction
  logic [smeu_pkg::CMD_W-1:0] opc_r;
  logic [W-1:0] opnd_r, inval_r;
  // operands read from the stores
  logic [W-1:0] top_r, nxt_r;
  logic [W-1:0] glob_q;
  logic         gvld_r;
  // architectural state
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [AW-1:0]   ip_r, ip_nxt;
  logic            halt_r, halt_nxt;
  logic [GLOBAL_N-1:0] gvalid_r;
  // pending result
  logic [ERR_W_L-1:0] err_r, err_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [W-1:0] ov_r, ov_nxt;
  // output register
  logic            oreg_vld_r;
  logic [AW-1:0]   o_addr_r;
  logic            o_ovalid_r;
  logic [W-1:0]    o_ov_r;
  logic            o_halt_r;
  logic [ERR_W_L-1:0] o_err_r;

  logic [SP_W-1:0] sp_m1, sp_m2;
  logic [SA_W-1:0] s_raddr, s_waddr;
  logic [W-1:0]    s_rdata, s_wdata;
  logic            s_we;
  logic [GA_W-1:0] g_addr;
  logic [W-1:0]    g_rdata, g_wdata;
  logic            g_we;
  logic [W-1:0]    quotient;
  logic            div_done;
  logic [AW-1:0]   here, jump_tgt;
  logic            bad_gaddr;
  logic [W-1:0]    arith;

  assign sp_m1  = sp_r - SP_W'(1);
  assign sp_m2  = sp_r - SP_W'(2);
  assign g_addr = opnd_r[GA_W-1:0];
  assign s_raddr = cmd.rd_next ? sp_m2[SA_W-1:0] : sp_m1[SA_W-1:0];
  assign glob_q = gvld_r ? g_rdata : '0;

  smeu_ram #(.WIDTH(W), .DEPTH(smeu_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  smeu_ram #(.WIDTH(W), .DEPTH(GLOBAL_N)) u_glob (
    .clk(clk), .we(g_we), .waddr(g_addr), .wdata(g_wdata),
    .raddr(g_addr), .rdata(g_rdata)
  );

  smeu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(top_r), .divisor(nxt_r), .done(div_done), .quotient(quotient)
  );

  // capture path
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      opc_r   <= in_command;
      opnd_r  <= in_operand;
      inval_r <= in_in_value;
    end
    if (cmd.rd_top) begin
      gvld_r <= gvalid_r[g_addr];
    end
    if (cmd.rd_next) begin
      top_r <= s_rdata;
    end
    if (cmd.cap_next) begin
      nxt_r <= s_rdata;
    end
  end

  assign here      = ip_r;
  assign jump_tgt  = ip_r + opnd_r[AW-1:0];
  assign bad_gaddr = opnd_r >= W'(GLOBAL_N);

  // arithmetic result
  always_comb begin
    unique case (opc_r[1:0])
      2'd0:    arith = top_r + nxt_r;
      2'd1:    arith = top_r - nxt_r;
      2'd2:    arith = top_r * nxt_r;
      default: arith = quotient;
    endcase
  end

  // instruction commit
  always_comb begin
    sp_nxt     = sp_r;
    ip_nxt     = here + AW'(1);
    halt_nxt   = halt_r;
    err_nxt    = smeu_pkg::ERR_NONE;
    ovalid_nxt = 1'b0;
    ov_nxt     = '0;
    s_we       = 1'b0;
    s_waddr    = sp_r[SA_W-1:0];
    s_wdata    = opnd_r;
    g_we       = 1'b0;
    g_wdata    = top_r;
    if (halt_r) begin
      ip_nxt = here;
    end else begin
      unique case (opc_r)
        smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: begin
          if (sp_r < SP_W'(2)) begin
            err_nxt = smeu_pkg::ERR_UNDERFLOW;
          end else if (opc_r == smeu_pkg::OP_DIV && nxt_r == '0) begin
            err_nxt = smeu_pkg::ERR_DIV_ZERO;
          end else begin
            s_we    = 1'b1;
            s_waddr = sp_m2[SA_W-1:0];
            s_wdata = arith;
            sp_nxt  = sp_m1;
          end
        end
        smeu_pkg::OP_HALT: begin
          halt_nxt = 1'b1;
        end
        smeu_pkg::OP_JMP: begin
          ip_nxt = jump_tgt;
        end
        smeu_pkg::OP_JZ, smeu_pkg::OP_JNZ: begin
          if (sp_r == '0) begin
            err_nxt = smeu_pkg::ERR_UNDERFLOW;
          end else begin
            sp_nxt = sp_m1;
            if ((opc_r == smeu_pkg::OP_JZ) == (top_r == '0)) begin
              ip_nxt = jump_tgt;
            end
          end
        end
        smeu_pkg::OP_IN, smeu_pkg::OP_LDC: begin
          if (sp_r >= SP_W'(smeu_pkg::STACK_DEPTH)) begin
            err_nxt = smeu_pkg::ERR_OVERFLOW;
          end else begin
            s_we    = 1'b1;
            s_wdata = (opc_r == smeu_pkg::OP_IN) ? inval_r : opnd_r;
            sp_nxt  = sp_r + SP_W'(1);
          end
        end
        smeu_pkg::OP_OUT: begin
          if (sp_r == '0) begin
            err_nxt = smeu_pkg::ERR_UNDERFLOW;
          end else begin
            ov_nxt     = top_r;
            ovalid_nxt = 1'b1;
            sp_nxt     = sp_m1;
          end
        end
        smeu_pkg::OP_LDV: begin
          if (bad_gaddr) begin
            err_nxt = smeu_pkg::ERR_BAD_ADDR;
          end else if (sp_r >= SP_W'(smeu_pkg::STACK_DEPTH)) begin
            err_nxt = smeu_pkg::ERR_OVERFLOW;
          end else begin
            s_we    = 1'b1;
            s_wdata = glob_q;
            sp_nxt  = sp_r + SP_W'(1);
          end
        end
        smeu_pkg::OP_ST: begin
          if (bad_gaddr) begin
            err_nxt = smeu_pkg::ERR_BAD_ADDR;
          end else if (sp_r == '0) begin
            err_nxt = smeu_pkg::ERR_UNDERFLOW;
          end else begin
            g_we   = 1'b1;
            sp_nxt = sp_m1;
          end
        end
        default: begin
          err_nxt  = smeu_pkg::ERR_BAD_CMD;
          halt_nxt = 1'b1;
        end
      endcase
      if (err_nxt != smeu_pkg::ERR_NONE) begin
        ip_nxt = here;
      end
    end
    if (!cmd.exec) begin
      s_we = 1'b0;
      g_we = 1'b0;
    end
  end

  // architectural registers and global valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r     <= '0;
      ip_r     <= '0;
      halt_r   <= 1'b0;
      gvalid_r <= '0;
    end else if (cmd.exec) begin
      sp_r   <= sp_nxt;
      ip_r   <= ip_nxt;
      halt_r <= halt_nxt;
      if (g_we) begin
        gvalid_r[g_addr] <= 1'b1;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oreg_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      oreg_vld_r <= 1'b1;
    end else if (out_ready) begin
      oreg_vld_r <= 1'b0;
    end
    if (cmd.load_out) begin
      o_addr_r   <= ip_r;
      o_ovalid_r <= ovalid_r;
      o_ov_r     <= ov_r;
      o_halt_r   <= halt_r;
      o_err_r    <= err_r;
    end
  end

  assign stat.div_done  = div_done;
  assign stat.out_free  = !oreg_vld_r || out_ready;

  assign out_valid        = oreg_vld_r;
  assign out_next_address = o_addr_r;
  assign out_out_valid    = o_ovalid_r;
  assign out_out_value    = o_ov_r;
  assign out_halted       = o_halt_r;
  assign out_error_code   = o_err_r;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(smeu_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared");
  a_halted_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && halt_r) |=> ($stable(sp_r) && $stable(ip_r)))
    else $error("state changed while halted");
`endif

endmodule
`default_nettype wire

FILE: rtl/smeu_ctrl.sv
// Controller state machine: sequences reads, division, commit and output.
// Depends on smeu_pkg.
`default_nettype none
module smeu_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [smeu_pkg::CMD_W-1:0] in_command,
  input  wire smeu_pkg::dp_stat_t         stat,
  output smeu_pkg::dp_cmd_t               cmd
);

  smeu_pkg::state_t state_r, state_nxt;
  logic [smeu_pkg::CMD_W-1:0] opc_r, opc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smeu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    opc_r <= opc_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    opc_nxt   = opc_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      smeu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          opc_nxt   = in_command;
          state_nxt = smeu_pkg::ST_RD0;
        end
      end
      smeu_pkg::ST_RD0: begin
        cmd.rd_top = 1'b1;
        state_nxt  = smeu_pkg::ST_RD1;
      end
      smeu_pkg::ST_RD1: begin
        cmd.rd_next = 1'b1;
        state_nxt   = smeu_pkg::ST_RD2;
      end
      smeu_pkg::ST_RD2: begin
        cmd.cap_next = 1'b1;
        state_nxt = (opc_r == smeu_pkg::OP_DIV) ? smeu_pkg::ST_DIVS : smeu_pkg::ST_EXEC;
      end
      smeu_pkg::ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = smeu_pkg::ST_DIVW;
      end
      smeu_pkg::ST_DIVW: begin
        if (stat.div_done) begin
          state_nxt = smeu_pkg::ST_EXEC;
        end
      end
      smeu_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = smeu_pkg::ST_DONE;
      end
      smeu_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = smeu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smeu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/stack_machine_execute_unit.sv
// Stack machine execute unit, one instruction per input transaction.
// Each command runs through states RD0, RD1, RD2, EXEC and DONE; DIV also
// uses DIVS and DIVW for the 32-step iterative divider, and only one
// instruction is in flight at a time; DONE waits while the output stalls.
// Synchronous active-low reset clears stack pointer, address, halt flag and
// global-word valid bits; no clearing pass is needed.
`default_nettype none
module stack_machine_execute_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [smeu_pkg::CMD_W-1:0]          in_command,
  input  wire logic signed [31:0]                  in_operand,
  input  wire logic signed [31:0]                  in_in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [smeu_pkg::ADDRESS_BITS-1:0]        out_next_address,
  output logic                                     out_out_valid,
  output logic signed [31:0]                       out_out_value,
  output logic                                     out_halted,
  output logic [smeu_pkg::ERR_W-1:0]               out_error_code
);

  smeu_pkg::dp_cmd_t  cmd;
  smeu_pkg::dp_stat_t stat;

  smeu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .stat(stat), .cmd(cmd)
  );

  smeu_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_command(in_command), .in_operand(in_operand), .in_in_value(in_in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_next_address(out_next_address), .out_out_valid(out_out_valid),
    .out_out_value(out_out_value), .out_halted(out_halted),
    .out_error_code(out_error_code)
  );

endmodule
`default_nettype wire
